@@ rtl/hbd_pkg.sv @@
package hbd_pkg;

	localparam int TAP_RADIUS     = 31;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_FRAC_BITS = 17;

	localparam int NPAIR      = (TAP_RADIUS + 1) / 2;
	localparam int NSTEP      = NPAIR + 1;
	localparam int STEP_W     = $clog2(NSTEP);
	localparam int HIST_DEPTH = 1 << $clog2(2 * TAP_RADIUS + 2);
	localparam int AW         = $clog2(HIST_DEPTH);
	localparam int MAX_OUT    = TAP_RADIUS / 2 + 1;
	localparam int CNT_W      = $clog2(MAX_OUT + 1);
	localparam int TAP_W      = COEF_FRAC_BITS + 2;
	localparam int OPD_W      = SAMPLE_BITS + 1;
	localparam int PROD_W     = OPD_W + TAP_W;
	localparam int ACC_W      = PROD_W + $clog2(NSTEP);
	localparam int CTR_W      = 32;
	localparam int POS_W      = CTR_W + 3;

	localparam longint unsigned PI_HALF_Q29 = 64'd843314857;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} hbd_state_t;

	typedef struct packed {
		logic              wr_en;
		logic [AW-1:0]     wr_addr;
		logic              load_first;
		logic              step_valid;
		logic              step_first;
		logic              step_last;
		logic [STEP_W-1:0] step;
		logic [CTR_W-1:0]  n;
		logic [CTR_W-1:0]  i;
		logic              load_out;
		logic              out_last;
		logic              mono;
	} hbd_cmd_t;

	typedef struct packed {
		logic acc_done;
	} hbd_stat_t;

	typedef logic [NPAIR:0][TAP_W-1:0] hbd_tap_vec_t;

	// shift-subtract quotient, used only while building the constant taps
	function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned rem;
		q   = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem  = rem - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned kaiser_i0(longint unsigned num, longint unsigned den);
		longint unsigned sum;
		longint unsigned term;
		longint unsigned kk;
		logic            run;
		sum  = 64'd1 << 32;
		term = 64'd1 << 32;
		run  = 1'b1;
		for (int k = 1; k < 64; k++) begin
			kk = longint'(k);
			if (run) begin
				term = udiv(term * num, den * kk * kk);
				if (term == 64'd0)
					run = 1'b0;
				else
					sum = sum + term;
			end
		end
		return sum;
	endfunction

	function automatic longint unsigned tap_mag(int a);
		longint unsigned rr;
		longint unsigned aa;
		longint unsigned i0;
		rr = longint'(TAP_RADIUS) * longint'(TAP_RADIUS);
		aa = longint'(a);
		i0 = kaiser_i0(64'd81 * (rr - aa * aa), 64'd4 * rr);
		if (a == 0)
			return ((i0 >> 8) * PI_HALF_Q29) >> 29;
		else if ((a % 2) == 0)
			return 64'd0;
		else
			return udiv(i0, aa) >> 8;
	endfunction

	function automatic logic tap_neg(int a);
		return ((a % 2) == 1) && ((((a - 1) / 2) % 2) == 1);
	endfunction

	function automatic hbd_tap_vec_t build_taps();
		hbd_tap_vec_t    t;
		longint          s;
		longint unsigned q;
		longint          sq;
		int              a;
		s = 0;
		for (int n = -TAP_RADIUS; n <= TAP_RADIUS; n++) begin
			a = (n < 0) ? -n : n;
			if (tap_neg(a))
				s = s - longint'(tap_mag(a));
			else
				s = s + longint'(tap_mag(a));
		end
		for (int k = 0; k <= NPAIR; k++) begin
			a  = (k == 0) ? 0 : 2 * k - 1;
			q  = udiv((tap_mag(a) << (COEF_FRAC_BITS + 1)) + longint'(s),
				64'd2 * longint'(s));
			sq = tap_neg(a) ? -longint'(q) : longint'(q);
			t[k] = sq[TAP_W-1:0];
		end
		return t;
	endfunction

	localparam hbd_tap_vec_t TAPS = build_taps();

endpackage

@@ rtl/hbd_if.sv @@
interface hbd_in_if import hbd_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;
	logic                          last_frame;

	modport source (output valid, sample_left, sample_right, last_frame, input ready);
	modport sink   (input valid, sample_left, sample_right, last_frame, output ready);
endinterface

interface hbd_out_if import hbd_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic                          out_last;

	modport source (output valid, out_left, out_right, out_last, input ready);
	modport sink   (input valid, out_left, out_right, out_last, output ready);
endinterface

@@ rtl/halfband_decimator_2to1.sv @@
// channel     dir   handshake        payload
// frame_in    in    valid / ready    sample_left, sample_right, last_frame
// frame_out   out   valid / ready    out_left, out_right, out_last
// cfg         in    cfg_valid/ready  cfg_data = two_channels
//
// Each output takes one check, 17 steps of the shared multiply-accumulate (center tap
// plus 16 symmetric pairs), a pipeline drain and a load, which waits until the output
// register is free. An item that releases no output goes back to idle after the check;
// the last item of a run adds the flush. The two-read history memory sets the pace.
// Reset is asynchronous, no clearing pass. A stalled output holds its item; the next
// input item is taken meanwhile once no other output of the item is pending.
module halfband_decimator_2to1 import hbd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	hbd_in_if.sink    frame_in,
	hbd_out_if.source frame_out,
	input  logic   cfg_valid,
	output logic   cfg_ready,
	input  logic   cfg_data
);

	hbd_cmd_t  cmd;
	hbd_stat_t stat;

	hbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame_in.valid),
		.in_ready  (frame_in.ready),
		.in_last   (frame_in.last_frame),
		.out_valid (frame_out.valid),
		.out_ready (frame_out.ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	hbd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample_left  (frame_in.sample_left),
		.sample_right (frame_in.sample_right),
		.stat         (stat),
		.out_left     (frame_out.out_left),
		.out_right    (frame_out.out_right),
		.out_last     (frame_out.out_last)
	);

endmodule

@@ rtl/hbd_ctrl.sv @@
module hbd_ctrl import hbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      in_last,
	output logic      out_valid,
	input  logic      out_ready,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data,
	output hbd_cmd_t  cmd,
	input  hbd_stat_t stat
);

	hbd_state_t        state_q, state_d;
	logic [CTR_W-1:0]  frames_q, next_q, cur_i_q;
	logic [CTR_W:0]    limit_q, limit_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] step_q;
	logic              last_q, two_ch_q, out_valid_q;
	logic              accept, pending, end_run;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_comb begin
		if (in_last)
			limit_d = ({1'b0, frames_q} + (CTR_W+1)'(2)) >> 1;
		else if (frames_q >= CTR_W'(TAP_RADIUS))
			limit_d = (({1'b0, frames_q} - (CTR_W+1)'(TAP_RADIUS)) >> 1) + (CTR_W+1)'(1);
		else
			limit_d = '0;
	end

	assign pending = ({1'b0, next_q} < limit_q) && (cnt_q < CNT_W'(MAX_OUT));

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		accept         = 1'b0;
		end_run        = 1'b0;
		cmd            = '0;
		cmd.wr_addr    = frames_q[AW-1:0];
		cmd.step       = step_q;
		cmd.step_first = (step_q == '0);
		cmd.step_last  = (step_q == STEP_W'(NPAIR));
		cmd.n          = next_q;
		cmd.i          = cur_i_q;
		cmd.out_last   = last_q && (({1'b0, next_q} + (CTR_W+1)'(1)) == limit_q);
		cmd.mono       = !two_ch_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept         = 1'b1;
					cmd.wr_en      = 1'b1;
					cmd.load_first = (frames_q == '0);
					state_d        = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (pending) begin
					state_d = ST_RUN;
				end else begin
					end_run = last_q;
					state_d = ST_IDLE;
				end
			end
			ST_RUN: begin
				cmd.step_valid = 1'b1;
				if (step_q == STEP_W'(NPAIR))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (stat.acc_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q    <= '0;
			next_q      <= '0;
			cur_i_q     <= '0;
			limit_q     <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			last_q      <= 1'b0;
			two_ch_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				two_ch_q <= cfg_data;
			if (accept) begin
				cur_i_q  <= frames_q;
				frames_q <= frames_q + CTR_W'(1);
				last_q   <= in_last;
				limit_q  <= limit_d;
				cnt_q    <= '0;
			end
			if (state_q == ST_CHECK)
				step_q <= '0;
			else if (cmd.step_valid)
				step_q <= step_q + STEP_W'(1);
			if (end_run) begin
				frames_q <= '0;
				next_q   <= '0;
			end
			if (cmd.load_out) begin
				next_q      <= next_q + CTR_W'(1);
				cnt_q       <= cnt_q + CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/hbd_datapath.sv @@
module hbd_datapath import hbd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hbd_cmd_t                      cmd,
	input  logic signed [SAMPLE_BITS-1:0] sample_left,
	input  logic signed [SAMPLE_BITS-1:0] sample_right,
	output hbd_stat_t                     stat,
	output logic signed [SAMPLE_BITS-1:0] out_left,
	output logic signed [SAMPLE_BITS-1:0] out_right,
	output logic                          out_last
);

	logic [SAMPLE_BITS-1:0] mem_l [HIST_DEPTH];
	logic [SAMPLE_BITS-1:0] mem_r [HIST_DEPTH];
	logic [SAMPLE_BITS-1:0] first_l_q, first_r_q;

	logic signed [POS_W-1:0] pos_i, pos_c, pos_a, pos_b, pac, pbc;
	logic [AW-1:0]           addr_a, addr_b;
	logic                    fa, fb;

	logic                   v_s1, first_s1, last_s1, ctr_s1, fa_s1, fb_s1;
	logic [STEP_W-1:0]      k_s1;
	logic [SAMPLE_BITS-1:0] rd_la_s1, rd_lb_s1, rd_ra_s1, rd_rb_s1;

	logic                    v_s2, first_s2, last_s2;
	logic signed [OPD_W-1:0] sum_l_s2, sum_r_s2;
	logic signed [TAP_W-1:0] tap_s2;
	logic [SAMPLE_BITS-1:0]  xa_l, xb_l, xa_r, xb_r;

	logic                     v_s3, first_s3, last_s3;
	logic signed [PROD_W-1:0] prod_l_s3, prod_r_s3;

	logic signed [ACC_W-1:0] acc_l_q, acc_r_q;
	logic                    done_q;

	function automatic logic [SAMPLE_BITS-1:0] round_sat(logic signed [ACC_W-1:0] acc);
		logic [ACC_W-1:0]       mag;
		logic [ACC_W-1:0]       r;
		logic [ACC_W-1:0]       maxp;
		logic [SAMPLE_BITS-1:0] neg_r;
		maxp = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
		mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
		r    = (mag + (ACC_W'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
		neg_r = SAMPLE_BITS'(-r);
		if (!acc[ACC_W-1])
			return (r > maxp) ? maxp[SAMPLE_BITS-1:0] : r[SAMPLE_BITS-1:0];
		else
			return (r > maxp) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : neg_r;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_l[cmd.wr_addr] <= sample_left;
			mem_r[cmd.wr_addr] <= sample_right;
		end
		rd_la_s1 <= mem_l[addr_a];
		rd_lb_s1 <= mem_l[addr_b];
		rd_ra_s1 <= mem_r[addr_a];
		rd_rb_s1 <= mem_r[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_l_q <= '0;
			first_r_q <= '0;
		end else if (cmd.load_first) begin
			first_l_q <= sample_left;
			first_r_q <= sample_right;
		end
	end

	// tap pair k covers offsets +/-(2k-1); k = 0 is the center tap
	always_comb begin
		pos_i = $signed({3'b000, cmd.i});
		pos_c = $signed({2'b00, cmd.n, 1'b0});
		if (cmd.step == '0) begin
			pos_a = pos_c;
			pos_b = pos_c;
		end else begin
			pos_a = pos_c + $signed(POS_W'({cmd.step, 1'b0})) - POS_W'(1);
			pos_b = pos_c - $signed(POS_W'({cmd.step, 1'b0})) + POS_W'(1);
		end
		pac    = (pos_a > pos_i) ? pos_i : pos_a;
		pbc    = (pos_b > pos_i) ? pos_i : pos_b;
		fa     = (pac <= 0);
		fb     = (pbc <= 0);
		addr_a = pac[AW-1:0];
		addr_b = pbc[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= cmd.step_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.step_first;
		last_s1  <= cmd.step_last;
		ctr_s1   <= (cmd.step == '0);
		k_s1     <= cmd.step;
		fa_s1    <= fa;
		fb_s1    <= fb;
	end

	always_comb begin
		xa_l = fa_s1 ? first_l_q : rd_la_s1;
		xa_r = fa_s1 ? first_r_q : rd_ra_s1;
		xb_l = ctr_s1 ? '0 : (fb_s1 ? first_l_q : rd_lb_s1);
		xb_r = ctr_s1 ? '0 : (fb_s1 ? first_r_q : rd_rb_s1);
	end

	always_ff @(posedge clk) begin
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		sum_l_s2 <= OPD_W'($signed(xa_l)) + OPD_W'($signed(xb_l));
		sum_r_s2 <= OPD_W'($signed(xa_r)) + OPD_W'($signed(xb_r));
		tap_s2   <= $signed(TAPS[k_s1]);
		first_s3  <= first_s2;
		last_s3   <= last_s2;
		prod_l_s3 <= PROD_W'(sum_l_s2 * tap_s2);
		prod_r_s3 <= PROD_W'(sum_r_s2 * tap_s2);
		if (v_s3) begin
			acc_l_q <= first_s3 ? ACC_W'(prod_l_s3) : acc_l_q + ACC_W'(prod_l_s3);
			acc_r_q <= first_s3 ? ACC_W'(prod_r_s3) : acc_r_q + ACC_W'(prod_r_s3);
		end
		if (cmd.load_out) begin
			out_left  <= round_sat(acc_l_q);
			out_right <= cmd.mono ? '0 : round_sat(acc_r_q);
			out_last  <= cmd.out_last;
		end
	end

	assign stat.acc_done = done_q;

endmodule

@@ rtl/hbd_checker.sv @@
module hbd_checker import hbd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_left,
	input logic [SAMPLE_BITS-1:0] out_right,
	input logic                   out_last,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic                   cfg_data
);

	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b1;
		else if (cfg_valid && cfg_ready)
			mode_q <= cfg_data;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right)
			&& $stable(out_last))
		else $error("output item changed while stalled");

	a_mono_right: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mode_q |-> out_right == '0)
		else $error("right output nonzero in mono");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous item is in work");

	a_new_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready)
		else $error("output item appeared while idle");

endmodule

bind halfband_decimator_2to1 hbd_checker u_hbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame_in.valid),
	.in_ready  (frame_in.ready),
	.out_valid (frame_out.valid),
	.out_ready (frame_out.ready),
	.out_left  (frame_out.out_left),
	.out_right (frame_out.out_right),
	.out_last  (frame_out.out_last),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_data  (cfg_data)
);

@@ tb/sv/tb.sv @@
module tb;
	import hbd_pkg::*;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               last;
	} frame_t;

	localparam int RADIUS   = 31;
	localparam int RING     = 128;
	localparam int WD_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b1;

	hbd_in_if  frame_in();
	hbd_out_if frame_out();

	halfband_decimator_2to1 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_in  (frame_in),
		.frame_out (frame_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	frame_t frames_q[$];
	frame_t decimated_q[$];
	int     errors = 0;
	int     send_idle = 0;
	int     recv_stall = 0;
	int     mode_reqs = 0;
	int     mode_acks = 0;
	logic   mode_value = 1'b1;
	int     quiet_cycles = 0;

	longint coef[2*RADIUS+1];
	int     ring_left[RING];
	int     ring_right[RING];
	int     first_left;
	int     first_right;
	longint frames_seen;
	longint next_out;
	logic   stereo;

	function automatic longint unsigned bessel_i0(longint unsigned num, longint unsigned den);
		longint unsigned sum;
		longint unsigned term;
		logic            run;
		sum  = 64'd1 << 32;
		term = 64'd1 << 32;
		run  = 1'b1;
		for (int k = 1; k < 64; k++) begin
			if (run) begin
				term = term * num / (den * longint'(k) * longint'(k));
				if (term == 0)
					run = 1'b0;
				else
					sum += term;
			end
		end
		return sum;
	endfunction

	function automatic void make_coefs();
		longint unsigned mag[2*RADIUS+1];
		logic            neg[2*RADIUS+1];
		longint unsigned rr;
		longint unsigned a;
		longint unsigned i0;
		longint          s;
		longint          q;
		rr = RADIUS * RADIUS;
		s  = 0;
		for (int n = -RADIUS; n <= RADIUS; n++) begin
			a  = (n < 0) ? -n : n;
			i0 = bessel_i0(64'd81 * (rr - a * a), 64'd4 * rr);
			neg[n+RADIUS] = 1'b0;
			if (a == 0)
				mag[n+RADIUS] = ((i0 >> 8) * 64'd843314857) >> 29;
			else if (a[0] == 1'b0)
				mag[n+RADIUS] = 0;
			else begin
				mag[n+RADIUS] = (i0 / a) >> 8;
				neg[n+RADIUS] = (((a - 1) / 2) % 2) == 1;
			end
			s += neg[n+RADIUS] ? -longint'(mag[n+RADIUS]) : longint'(mag[n+RADIUS]);
		end
		for (int n = 0; n < 2*RADIUS+1; n++) begin
			q = longint'(((mag[n] << 18) + longint'(s)) / (64'd2 * longint'(s)));
			coef[n] = neg[n] ? -q : q;
		end
	endfunction

	function automatic logic signed [15:0] fir_point(logic right_ch, longint n, longint lastpos);
		longint acc;
		longint pos;
		longint x;
		longint r;
		acc = 0;
		for (int m = -RADIUS; m <= RADIUS; m++) begin
			pos = 2 * n + m;
			if (pos > lastpos)
				pos = lastpos;
			if (pos <= 0)
				x = right_ch ? first_right : first_left;
			else
				x = right_ch ? ring_right[pos % RING] : ring_left[pos % RING];
			acc += x * coef[m+RADIUS];
		end
		if (acc >= 0)
			r = (acc + (64'd1 << 16)) >>> 17;
		else
			r = -((-acc + (64'd1 << 16)) >>> 17);
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	function automatic void decimate(frame_t f);
		longint i;
		longint upto;
		frame_t o;
		i = frames_seen;
		ring_left[i % RING]  = f.left;
		ring_right[i % RING] = f.right;
		if (i == 0) begin
			first_left  = f.left;
			first_right = f.right;
		end
		frames_seen = i + 1;
		if (f.last)
			upto = (i + 2) / 2;
		else if (i >= RADIUS)
			upto = (i - RADIUS) / 2 + 1;
		else
			upto = 0;
		while (next_out < upto) begin
			o.left  = fir_point(1'b0, next_out, i);
			o.right = stereo ? fir_point(1'b1, next_out, i) : 16'sd0;
			o.last  = f.last && (next_out + 1 == upto);
			decimated_q.push_back(o);
			next_out++;
		end
		if (f.last) begin
			frames_seen = 0;
			next_out    = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_t f;
		if (!arst_n) begin
			frame_in.valid        <= 1'b0;
			frame_in.sample_left  <= '0;
			frame_in.sample_right <= '0;
			frame_in.last_frame   <= 1'b0;
		end else begin
			if (frame_in.valid && frame_in.ready) begin
				f.left  = frame_in.sample_left;
				f.right = frame_in.sample_right;
				f.last  = frame_in.last_frame;
				decimate(f);
			end
			if (!frame_in.valid || frame_in.ready) begin
				if (frames_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					f = frames_q.pop_front();
					frame_in.valid        <= 1'b1;
					frame_in.sample_left  <= f.left;
					frame_in.sample_right <= f.right;
					frame_in.last_frame   <= f.last;
				end else
					frame_in.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		frame_t e;
		if (!arst_n)
			frame_out.ready <= 1'b0;
		else begin
			frame_out.ready <= ($urandom_range(99) >= recv_stall);
			if (frame_out.valid && frame_out.ready) begin
				if (decimated_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected item left=%0d right=%0d last=%0b", $time,
						frame_out.out_left, frame_out.out_right, frame_out.out_last);
				end else begin
					e = decimated_q.pop_front();
					if (frame_out.out_left !== e.left || frame_out.out_right !== e.right
						|| frame_out.out_last !== e.last) begin
						errors++;
						$display("%0t: expected left=%0d right=%0d last=%0b, got %0d %0d %0b",
							$time, e.left, e.right, e.last, frame_out.out_left,
							frame_out.out_right, frame_out.out_last);
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_data  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			cfg_valid <= 1'b0;
			stereo = cfg_data;
			mode_acks++;
		end else if (mode_reqs > mode_acks && !cfg_valid) begin
			cfg_valid <= 1'b1;
			cfg_data  <= mode_value;
		end
	end

	always @(posedge clk) begin
		if ((frame_in.valid && frame_in.ready) || (frame_out.valid && frame_out.ready)
			|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_run(int len, int style);
		frame_t f;
		for (int k = 0; k < len; k++) begin
			case (style)
				1: begin
					f.left  = k[0] ? 16'sh8000 : 16'sh7fff;
					f.right = k[0] ? 16'sh7fff : 16'sh8000;
				end
				2: begin
					f.left  = 16'sh7fff;
					f.right = 16'sh8000;
				end
				default: begin
					f.left  = pick_sample();
					f.right = pick_sample();
				end
			endcase
			f.last = (k == len - 1);
			frames_q.push_back(f);
		end
	endtask

	task automatic drain();
		while (frames_q.size() > 0 || decimated_q.size() > 0 || frame_in.valid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_mode(logic v);
		mode_value = v;
		mode_reqs++;
		while (mode_acks < mode_reqs)
			@(posedge clk);
	endtask

	initial begin
		int budget;
		int len;
		make_coefs();
		stereo      = 1'b1;
		frames_seen = 0;
		next_out    = 0;
		first_left  = 0;
		first_right = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_run(1, 2);
		add_run(2, 0);
		add_run(20, 1);
		add_run(50, 0);
		drain();
		set_mode(1'b0);
		add_run(3, 1);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 53; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 53; end
				default: begin send_idle = 17; recv_stall = 17; end
			endcase
			set_mode(ph[0]);
			budget = 32;
			while (budget > 0) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(30, 70);
				if (len > budget)
					len = budget;
				add_run(len, ($urandom_range(9) == 0) ? 1 : 0);
				budget -= len;
			end
			drain();
		end
		set_mode(1'b1);
		send_idle  = 0;
		recv_stall = 0;
		add_run(5, 0);
		drain();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
